// ===== rtl/spq_pkg.sv =====
package spq_pkg;

   // Fixed widths of the transaction fields and the scale mask.
   localparam int PITCH_W = 14;
   localparam int MASK_W  = 12;
   localparam int SEMI_W  = 8;

   // Internal widths, sized for the largest supported octave range.
   localparam int OCT_W   = 4;
   localparam int BASE_W  = 7;
   localparam int IDX_W   = 4;
   localparam int DIST_W  = 4;

   // Twelve pitch classes per octave; the rounded index may reach twelve.
   localparam logic [IDX_W-1:0] NUM_CLASSES = 4'd12;

   // Largest search distance: six steps reach every class both ways.
   localparam int MAX_DIST = 6;

   // Scale mask after reset: the whole-tone pattern.
   localparam logic [MASK_W-1:0] MASK_RESET = 12'h555;

   // Note handed from the split stages to the search stages.
   typedef struct packed {
      logic [BASE_W-1:0] base;      // octave times twelve
      logic [IDX_W-1:0]  idx;       // rounded semitone within octave, 0..12
      logic              frac_pos;  // pitch lies above the rounded index
   } spq_note_type;

endpackage

// ===== rtl/scale_pitch_quantizer.sv =====
// Throughput: one transaction per cycle while rsp_ready is high, through four register stages
// (octave count, rounding, mask search, final add).
// A transaction with gate low, or taken while the scale mask is empty, gives no result.
// Reset empties every stage and sets the scale mask to the whole-tone pattern.
module scale_pitch_quantizer #(
   parameter int FRACTION_BITS = 8,
   parameter int OCTAVES       = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_gate,
   input  logic [spq_pkg::PITCH_W-1:0]       req_pitch,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [spq_pkg::SEMI_W-1:0] rsp_semitone,
   input  logic                              csr_wr_en,
   input  logic [spq_pkg::MASK_W-1:0]        csr_wr_data
);
   import spq_pkg::*;

   logic [MASK_W-1:0] scale_mask_ff;
   logic              note_valid, note_ready;
   spq_note_type      note;

   // Scale mask register.
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_mask_ff <= MASK_RESET;
      end else if (csr_wr_en) begin
         scale_mask_ff <= csr_wr_data;
      end
   end

   spq_split #(
      .FRACTION_BITS (FRACTION_BITS),
      .OCTAVES       (OCTAVES)
   ) u_split (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_gate   (req_gate),
      .req_pitch  (req_pitch),
      .mask_empty (scale_mask_ff == '0),
      .note_valid (note_valid),
      .note_ready (note_ready),
      .note       (note)
   );

   spq_search u_search (
      .clock        (clock),
      .reset        (reset),
      .note_valid   (note_valid),
      .note_ready   (note_ready),
      .note         (note),
      .scale_mask   (scale_mask_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_semitone (rsp_semitone)
   );

endmodule

// ===== rtl/spq_split.sv =====
module spq_split #(
   parameter int FRACTION_BITS = 8,
   parameter int OCTAVES       = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_gate,
   input  logic [spq_pkg::PITCH_W-1:0] req_pitch,
   input  logic                        mask_empty,
   output logic                        note_valid,
   input  logic                        note_ready,
   output spq_pkg::spq_note_type       note
);
   import spq_pkg::*;

   localparam int unsigned SEMI_ONE  = 1 << FRACTION_BITS;
   localparam int unsigned HALF      = SEMI_ONE >> 1;
   localparam int unsigned OCT_UNITS = 12 * SEMI_ONE;
   localparam int unsigned PITCH_MAX = OCTAVES * OCT_UNITS;
   localparam logic [PITCH_W-1:0] PITCH_CAP =
      (PITCH_MAX > 16383) ? {PITCH_W{1'b1}} : PITCH_W'(PITCH_MAX);

   logic               s1_v_ff, s1_v_in;
   logic [PITCH_W-1:0] s1_pitch_ff;
   logic [OCT_W-1:0]   s1_oct_ff;
   logic               s2_v_ff, s2_v_in;
   spq_note_type       s2_note_ff;
   logic               s1_ready, s2_ready;

   logic [PITCH_W-1:0] pitch_sat;
   logic [OCTAVES-1:0] oct_ge;
   logic [OCT_W-1:0]   oct_c;
   logic [BASE_W-1:0]  base_c;
   logic [PITCH_W-1:0] within_c;
   logic [PITCH_W:0]   round_sum;
   logic [IDX_W-1:0]   idx_c;
   logic [PITCH_W:0]   idx_units;

   // A stage takes new data when it is empty or its content moves on.
   assign s2_ready  = !s2_v_ff || note_ready;
   assign s1_ready  = !s1_v_ff || s2_ready;
   assign req_ready = s1_ready;

   // Stage one: saturate the pitch and count the whole octaves below it.
   always_comb begin
      pitch_sat = (req_pitch > PITCH_CAP) ? PITCH_CAP : req_pitch;
      for (int k = 1; k <= OCTAVES; k++) begin
         oct_ge[k-1] = {{(32-PITCH_W){1'b0}}, pitch_sat} >= 32'(k * OCT_UNITS);
      end
      oct_c = OCT_W'($countones(oct_ge));
   end

   // Stage two: remove the octave, round the note half up, note the fraction sign.
   always_comb begin
      base_c    = BASE_W'({3'b000, s1_oct_ff} << 3) + BASE_W'({3'b000, s1_oct_ff} << 2);
      within_c  = s1_pitch_ff - PITCH_W'({base_c, {FRACTION_BITS{1'b0}}});
      round_sum = {1'b0, within_c} + (PITCH_W + 1)'(HALF);
      idx_c     = IDX_W'(round_sum >> FRACTION_BITS);
      idx_units = (PITCH_W + 1)'({idx_c, {FRACTION_BITS{1'b0}}});
   end

   // Valid bits; a transaction with gate low or an empty mask is dropped here.
   always_comb begin
      s1_v_in = s1_ready ? (req_valid && req_gate && !mask_empty) : s1_v_ff;
      s2_v_in = s2_ready ? s1_v_ff : s2_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   // Payload registers load whenever their stage advances.
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_pitch_ff <= pitch_sat;
         s1_oct_ff   <= oct_c;
      end
      if (s2_ready) begin
         s2_note_ff.base     <= base_c;
         s2_note_ff.idx      <= idx_c;
         s2_note_ff.frac_pos <= {1'b0, within_c} > idx_units;
      end
   end

   assign note_valid = s2_v_ff;
   assign note       = s2_note_ff;

`ifndef ASSERT_OFF
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_gate && !mask_empty |=> s1_v_ff)
      else $error("Gated transaction did not enter stage one.");
`endif

endmodule

// ===== rtl/spq_search.sv =====
module spq_search (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              note_valid,
   output logic                              note_ready,
   input  spq_pkg::spq_note_type             note,
   input  logic [spq_pkg::MASK_W-1:0]        scale_mask,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [spq_pkg::SEMI_W-1:0] rsp_semitone
);
   import spq_pkg::*;

   logic                     s3_v_ff, s3_v_in;
   logic [SEMI_W-1:0]        s3_sum_ff;
   logic signed [DIST_W-1:0] s3_dist_ff;
   logic                     out_v_ff, out_v_in;
   logic signed [SEMI_W-1:0] out_semi_ff;
   logic                     s3_ready, out_ready;

   logic [IDX_W-1:0]         cls;
   logic [2*MASK_W-1:0]      mask_pair;
   logic [MASK_W-1:0]        rot;
   logic signed [DIST_W-1:0] dist_c;

   assign out_ready  = !out_v_ff || rsp_ready;
   assign s3_ready   = !s3_v_ff || out_ready;
   assign note_ready = s3_ready;

   // Stage three: rotate the mask so the rounded class sits at bit zero,
   // then take the nearest active class, smallest distance first.
   always_comb begin
      cls       = (note.idx == NUM_CLASSES) ? '0 : note.idx;
      mask_pair = {scale_mask, scale_mask} >> cls;
      rot       = mask_pair[MASK_W-1:0];
      dist_c    = '0;
      for (int d = MAX_DIST; d >= 1; d--) begin
         if (rot[d] && rot[MASK_W-d]) begin
            dist_c = note.frac_pos ? DIST_W'(d) : DIST_W'(-d);
         end else if (rot[d]) begin
            dist_c = DIST_W'(d);
         end else if (rot[MASK_W-d]) begin
            dist_c = DIST_W'(-d);
         end
      end
      if (rot[0]) begin
         dist_c = '0;
      end
   end

   always_comb begin
      s3_v_in  = s3_ready ? note_valid : s3_v_ff;
      out_v_in = out_ready ? s3_v_ff : out_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s3_v_ff  <= s3_v_in;
         out_v_ff <= out_v_in;
      end
   end

   // Stage four adds the signed distance to octave base plus index.
   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_sum_ff  <= SEMI_W'(note.base) + SEMI_W'(note.idx);
         s3_dist_ff <= dist_c;
      end
      if (out_ready) begin
         out_semi_ff <= $signed(s3_sum_ff)
                        + {{(SEMI_W-DIST_W){s3_dist_ff[DIST_W-1]}}, s3_dist_ff};
      end
   end

   assign rsp_valid    = out_v_ff;
   assign rsp_semitone = out_semi_ff;

`ifndef ASSERT_OFF
   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      s3_v_ff |-> (s3_dist_ff <= 4'sd6) && (s3_dist_ff >= -4'sd6))
      else $error("Search distance out of range.");
   a_s3_hold: assert property (@(posedge clock) disable iff (reset)
      s3_v_ff && out_v_ff && !rsp_ready |=> s3_v_ff)
      else $error("Stage three lost a transaction under stall.");
   a_s3_load: assert property (@(posedge clock) disable iff (reset)
      note_valid && note_ready |=> s3_v_ff)
      else $error("Accepted note missing from stage three.");
`endif

endmodule

// ===== dv/spq_checker.sv =====
module spq_checker #(
   parameter int FRACTION_BITS = 8,
   parameter int OCTAVES       = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              req_gate,
   input  logic [spq_pkg::PITCH_W-1:0]       req_pitch,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [spq_pkg::SEMI_W-1:0] rsp_semitone,
   input  logic                              csr_wr_en,
   input  logic [spq_pkg::MASK_W-1:0]        csr_wr_data,
   output int                                mismatch_count,
   output int                                outstanding
);

   localparam int unsigned SEMI_ONE  = 1 << FRACTION_BITS;
   localparam int unsigned OCT_UNITS = 12 * SEMI_ONE;
   localparam int unsigned PITCH_MAX = OCTAVES * OCT_UNITS;

   // Scale mask as last written over the register port.
   logic [spq_pkg::MASK_W-1:0] scale_mask;

   // Semitones still owed by the block, oldest first.
   logic signed [spq_pkg::SEMI_W-1:0] owed_semitones[$];

   // Works out the snapped semitone for one pitch; returns zero when the mask is empty.
   function automatic bit snap_to_scale(input logic [spq_pkg::PITCH_W-1:0] pitch,
                                        input logic [spq_pkg::MASK_W-1:0] mask,
                                        output logic signed [spq_pkg::SEMI_W-1:0] semi);
      int unsigned p;
      int unsigned octave;
      int unsigned note_units;
      int unsigned idx;
      int          offset;
      int          total;
      bit          frac_pos;
      bit          found;
      bit          up;
      bit          dn;
      semi = '0;
      if (mask == '0) return 1'b0;
      p = 32'(pitch);
      if (p > PITCH_MAX) p = PITCH_MAX;
      octave     = p / OCT_UNITS;
      note_units = p % OCT_UNITS;
      idx        = (note_units + (SEMI_ONE >> 1)) >> FRACTION_BITS;
      offset     = 0;
      // Search outwards with wrap around the octave; a tie goes by the sign of the fraction.
      if (!mask[idx % 12]) begin
         frac_pos = note_units > (idx << FRACTION_BITS);
         found    = 1'b0;
         for (int d = 1; d <= 12 && !found; d++) begin
            up = mask[(idx + d) % 12];
            dn = mask[(idx + 24 - d) % 12];
            if (up && dn) begin
               offset = frac_pos ? d : -d;
               found  = 1'b1;
            end else if (up) begin
               offset = d;
               found  = 1'b1;
            end else if (dn) begin
               offset = -d;
               found  = 1'b1;
            end
         end
      end
      total = int'(octave * 12 + idx) + offset;
      semi  = total[spq_pkg::SEMI_W-1:0];
      return 1'b1;
   endfunction

   // Prints one line for a mismatch and counts it.
   task automatic report_mismatch(input string msg);
      $display("%0t spq_checker: %s", $realtime, msg);
      mismatch_count = mismatch_count + 1;
   endtask

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   // Tracks the mask, predicts each accepted transaction and compares each result.
   always @(posedge clock) begin
      logic signed [spq_pkg::SEMI_W-1:0] predicted;
      logic signed [spq_pkg::SEMI_W-1:0] owed;
      if (reset) begin
         scale_mask = spq_pkg::MASK_RESET;
         owed_semitones.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_semitones.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with none owed", rsp_semitone));
            end else begin
               owed = owed_semitones.pop_front();
               if (rsp_semitone !== owed) begin
                  report_mismatch($sformatf("semitone %0d, predicted %0d", rsp_semitone, owed));
               end
            end
         end
         if (req_valid && req_ready && req_gate) begin
            if (snap_to_scale(req_pitch, scale_mask, predicted)) begin
               owed_semitones.push_back(predicted);
            end
         end
         if (csr_wr_en) begin
            scale_mask = csr_wr_data;
         end
      end
      outstanding = owed_semitones.size();
   end

endmodule

// ===== dv/tb_scale_pitch_quantizer.sv =====
module tb_scale_pitch_quantizer;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic                              req_gate = 1'b0;
   logic [spq_pkg::PITCH_W-1:0]       req_pitch = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic signed [spq_pkg::SEMI_W-1:0] rsp_semitone;
   logic                              csr_wr_en = 1'b0;
   logic [spq_pkg::MASK_W-1:0]        csr_wr_data = '0;

   int                                mismatch_count;
   int                                outstanding;
   bit                                gaps_on = 1'b1;
   bit                                stalls_on = 1'b1;
   int                                stall_left = 0;

   scale_pitch_quantizer dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_gate     (req_gate),
      .req_pitch    (req_pitch),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_semitone (rsp_semitone),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   spq_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_gate       (req_gate),
      .req_pitch      (req_pitch),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_semitone   (rsp_semitone),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always #4 clock = ~clock;

   // Idle stretches are mostly short, now and then a long one.
   function automatic int idle_length();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Pitches: uniform, close to a semitone boundary, or near and above the top of the range.
   function automatic logic [spq_pkg::PITCH_W-1:0] pick_pitch();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return 14'($urandom_range(0, 16383));
      if (r < 85) return 14'($urandom_range(0, 60) * 256 + $urandom_range(0, 1) * 255
                             + $urandom_range(0, 1) * ($urandom_range(126, 129) - 0));
      return 14'($urandom_range(15300, 16383));
   endfunction

   // Result side: random back-pressure while stalls are enabled.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= idle_length() - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Offers one transaction, with an optional gap first, and returns at the edge that takes it.
   task automatic send_sample(input logic gate, input logic [spq_pkg::PITCH_W-1:0] pitch);
      int n;
      if (gaps_on && $urandom_range(0, 2) == 0) begin
         n = idle_length();
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_gate  <= gate;
      req_pitch <= pitch;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Holds the sender off until every owed result has come and the pipeline has emptied.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Writes the scale mask; only called while the block is idle.
   task automatic write_scale_mask(input logic [spq_pkg::MASK_W-1:0] mask);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mask;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Ends the run if the block hangs.
   initial begin
      #4000000;
      $display("end of test: mismatches");
      $finish;
   end

   // Stimulus: directed cases, then random phases under a range of masks.
   initial begin
      int counted;
      logic g;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset mask: gate low, rounding half up, ties both ways, top octave and saturation.
      send_sample(1'b0, 14'd0);
      send_sample(1'b1, 14'd0);
      send_sample(1'b1, 14'd127);
      send_sample(1'b1, 14'd128);
      send_sample(1'b1, 14'd256);
      send_sample(1'b1, 14'd300);
      send_sample(1'b1, 14'd3071);
      send_sample(1'b1, 14'd15360);
      send_sample(1'b1, 14'd16383);
      send_sample(1'b0, 14'd16383);
      wait_for_results();

      // Only the major seventh: the downward search wraps below zero.
      write_scale_mask(12'h800);
      send_sample(1'b1, 14'd0);
      send_sample(1'b1, 14'd1000);
      wait_for_results();

      // Only the tritone: a tie at the widest distance with no fraction goes down.
      write_scale_mask(12'h040);
      send_sample(1'b1, 14'd0);
      send_sample(1'b1, 14'd1586);
      wait_for_results();

      // Empty mask: no results at all.
      write_scale_mask(12'h000);
      send_sample(1'b1, 14'd0);
      send_sample(1'b1, 14'd15360);
      wait_for_results();

      // Every class active.
      write_scale_mask(12'hFFF);
      send_sample(1'b1, 14'd0);
      send_sample(1'b1, 14'd16383);
      send_sample(1'b1, 14'd3071);
      send_sample(1'b1, 14'd12345);
      wait_for_results();

      // Root only: a tie half an octave away, broken by a zero and a positive fraction.
      write_scale_mask(12'h001);
      send_sample(1'b1, 14'd1536);
      send_sample(1'b1, 14'd1537);
      wait_for_results();

      // A short stretch with the mask empty; none of it counts towards the random total.
      write_scale_mask(12'h000);
      repeat (30) send_sample(1'($urandom_range(0, 1)), pick_pitch());
      wait_for_results();

      // Random phases, each with its own mask and its own mix of gaps and stalls.
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0:       write_scale_mask(12'hFFF);
            1:       write_scale_mask(12'h001 << $urandom_range(0, 11));
            2:       write_scale_mask(spq_pkg::MASK_RESET);
            default: write_scale_mask(12'($urandom_range(1, 4095)));
         endcase
         gaps_on   = ($urandom_range(0, 3) != 0);
         stalls_on = ($urandom_range(0, 3) != 0);
         counted   = 0;
         while (counted < 100) begin
            g = ($urandom_range(0, 9) != 0);
            send_sample(g, pick_pitch());
            if (g) begin
               counted++;
               if (counted == 50) wait_for_results();
            end
         end
         wait_for_results();
      end

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
